/* rtl/pct_pkg.sv */
`timescale 1ns / 1ps

package pct_pkg;

	localparam int CoordWidth = 16;
	localparam int NCorners   = 4;
	localparam int NPlanes    = NCorners + 1;
	localparam int EpsQ14     = 164;

	localparam logic [1:0] MODE_CLEAR  = 2'd0;
	localparam logic [1:0] MODE_CORNER = 2'd1;
	localparam logic [1:0] MODE_TEST   = 2'd2;
	localparam logic [1:0] MODE_NOP    = 2'd3;

	typedef logic signed [CoordWidth-1:0] coord_t;
	typedef logic signed [15:0]           nrm_t;
	typedef logic signed [35:0]           raw_t;

	// control that rides with a product through the shared multiplier
	typedef struct packed {
		logic       vld;
		logic       sub;
		logic       first;
		logic       last;
		logic       fin;
		logic [2:0] tag;
	} mac_ctl_t;

	typedef struct packed {
		logic               done;
		logic               fin;
		logic [2:0]         tag;
		logic signed [39:0] sum;
	} mac_res_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_BASE,
		S_EA,
		S_EB,
		S_CROSS,
		S_CDRAIN,
		S_NORM,
		S_NWAIT,
		S_TEST,
		S_TDRAIN,
		S_THR,
		S_HDRAIN,
		S_DONE
	} seq_state_t;

	typedef enum logic [2:0] {
		N_IDLE,
		N_SHIFT,
		N_SQ,
		N_SQRT,
		N_DSET,
		N_DIV,
		N_DONE
	} norm_state_t;

endpackage

/* rtl/pct_mac.sv */
`timescale 1ns / 1ps

module pct_mac (
	input  logic               clk,
	input  logic               arst_n,
	input  pct_pkg::mac_ctl_t  ctl,
	input  logic signed [17:0] x,
	input  logic signed [17:0] y,
	output pct_pkg::mac_res_t  res
);

	logic signed [35:0] prod_s1;
	pct_pkg::mac_ctl_t  ctl_s1;
	logic signed [39:0] acc_q;
	logic               done_q;
	logic               fin_q;
	logic [2:0]         tag_q;
	logic signed [39:0] ext;
	logic signed [39:0] addend;
	logic signed [39:0] base;

	always_ff @(posedge clk) begin
		prod_s1 <= x * y;
	end

	always_comb begin
		ext    = {{4{prod_s1[35]}}, prod_s1};
		addend = ctl_s1.sub ? -ext : ext;
		base   = ctl_s1.first ? 40'sd0 : acc_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			done_q <= 1'b0;
			fin_q  <= 1'b0;
			tag_q  <= '0;
		end else begin
			ctl_s1 <= ctl;
			done_q <= ctl_s1.vld && ctl_s1.last;
			if (ctl_s1.vld) begin
				fin_q <= ctl_s1.fin;
				tag_q <= ctl_s1.tag;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl_s1.vld) begin
			acc_q <= base + addend;
		end
	end

	assign res.done = done_q;
	assign res.fin  = fin_q;
	assign res.tag  = tag_q;
	assign res.sum  = acc_q;

endmodule

/* rtl/pct_norm.sv */
`timescale 1ns / 1ps

module pct_norm (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  pct_pkg::raw_t vec [3],
	output logic          done,
	output pct_pkg::nrm_t n [3]
);

	pct_pkg::norm_state_t st_q, st_d;
	logic [35:0] a_q [3];
	logic        neg_q [3];
	logic [4:0]  cnt_q;
	logic [1:0]  ci_q;
	logic [45:0] prod_q;
	logic [47:0] s_q;
	logic [25:0] rem_q;
	logic [23:0] root_q;
	logic [37:0] num_q;
	logic [37:0] dsh_q;
	logic [14:0] q_q;
	logic [35:0] o;
	logic [26:0] remn;
	logic [26:0] trial;
	logic        ge_div;
	logic [14:0] qn;

	always_comb begin
		o      = a_q[0] | a_q[1] | a_q[2];
		remn   = {rem_q[24:0], s_q[47:46]};
		trial  = {1'b0, root_q, 2'b01};
		ge_div = num_q >= dsh_q;
		qn     = {q_q[13:0], ge_div};
	end

	// next state
	always_comb begin
		st_d = st_q;
		case (st_q)
			pct_pkg::N_IDLE:  if (start) st_d = pct_pkg::N_SHIFT;
			pct_pkg::N_SHIFT: begin
				if (o == '0) st_d = pct_pkg::N_DONE;
				else if (o[35:23] == '0 && o[22]) st_d = pct_pkg::N_SQ;
			end
			pct_pkg::N_SQ:    if (cnt_q == 5'd3) st_d = pct_pkg::N_SQRT;
			pct_pkg::N_SQRT:  if (cnt_q == 5'd23) st_d = pct_pkg::N_DSET;
			pct_pkg::N_DSET:  st_d = pct_pkg::N_DIV;
			pct_pkg::N_DIV: begin
				if (cnt_q == 5'd14)
					st_d = (ci_q == 2'd2) ? pct_pkg::N_DONE : pct_pkg::N_DSET;
			end
			pct_pkg::N_DONE:  st_d = pct_pkg::N_IDLE;
			default:          st_d = pct_pkg::N_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		done = (st_q == pct_pkg::N_DONE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) st_q <= pct_pkg::N_IDLE;
		else st_q <= st_d;
	end

	always_ff @(posedge clk) begin
		case (st_q)
			pct_pkg::N_IDLE: begin
				for (int i = 0; i < 3; i++) begin
					neg_q[i] <= vec[i][35];
					a_q[i]   <= vec[i][35] ? 36'(-vec[i]) : 36'(vec[i]);
				end
			end
			pct_pkg::N_SHIFT: begin
				cnt_q <= '0;
				s_q   <= '0;
				if (o == '0) begin
					for (int i = 0; i < 3; i++) n[i] <= '0;
				end else if (o[35:23] != '0) begin
					for (int i = 0; i < 3; i++) a_q[i] <= a_q[i] >> 1;
				end else if (!o[22]) begin
					for (int i = 0; i < 3; i++) a_q[i] <= a_q[i] << 1;
				end
			end
			pct_pkg::N_SQ: begin
				if (cnt_q < 5'd3) prod_q <= a_q[cnt_q[1:0]][22:0] * a_q[cnt_q[1:0]][22:0];
				if (cnt_q != 5'd0) s_q <= s_q + {2'b00, prod_q};
				if (cnt_q == 5'd3) begin
					cnt_q  <= '0;
					rem_q  <= '0;
					root_q <= '0;
				end else begin
					cnt_q <= cnt_q + 5'd1;
				end
			end
			pct_pkg::N_SQRT: begin
				// one result bit per cycle, two radicand bits consumed
				if (remn >= trial) begin
					rem_q  <= 26'(remn - trial);
					root_q <= {root_q[22:0], 1'b1};
				end else begin
					rem_q  <= remn[25:0];
					root_q <= {root_q[22:0], 1'b0};
				end
				s_q   <= s_q << 2;
				cnt_q <= cnt_q + 5'd1;
				ci_q  <= '0;
			end
			pct_pkg::N_DSET: begin
				num_q <= {1'b0, a_q[ci_q][22:0], 14'd0} + {14'd0, 1'b0, root_q[23:1]};
				dsh_q <= {root_q, 14'd0};
				q_q   <= '0;
				cnt_q <= '0;
			end
			pct_pkg::N_DIV: begin
				if (ge_div) num_q <= num_q - dsh_q;
				dsh_q <= dsh_q >> 1;
				q_q   <= qn;
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd14) begin
					n[ci_q] <= neg_q[ci_q] ? -$signed({1'b0, qn}) : $signed({1'b0, qn});
					ci_q    <= ci_q + 2'd1;
				end
			end
			default: ;
		endcase
	end

endmodule

/* rtl/prism_containment_test.sv */
`timescale 1ns / 1ps

// channel  dir  tuser (low first)  tdata (low first)
// s_*      in   mode[1:0]          px[15:0] py[31:16] pz[47:32]
// m_*      out  -                  inside_res[0] ready_res[1], zero pad to 8 bits
//
// one input word at a time; s_tready is high only while the sequencer idles
// test word: 15 multiplies on the shared multiplier
// fourth corner word: six normalizations on the iterative normalize unit;
// other words go straight from idle to the result
// a finished result waits in the output register while the next word is taken
// arst_n clears corner count and ready flag; stores fill before first read

module prism_containment_test (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [1:0]  s_tuser,   // mode
	input  logic [47:0] s_tdata,   // px, py, pz
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata    // inside_res, ready_res
);

	pct_pkg::seq_state_t state_q, state_d;

	// captured word
	logic [1:0]      mode_q;
	pct_pkg::coord_t v_q [3];

	// calibration stores
	pct_pkg::coord_t    corner_q [pct_pkg::NCorners][3];
	pct_pkg::nrm_t      nrm_q [pct_pkg::NPlanes][3];
	logic signed [35:0] thr_q [pct_pkg::NPlanes];
	logic [2:0]         count_q;
	logic               ready_q;
	logic               inside_q;

	// build sequencing
	logic               floorph_q;
	logic [2:0]         k_q;
	logic [1:0]         i_q;
	logic               h_q;
	pct_pkg::coord_t    base_q [3];
	logic signed [16:0] ea_q [3];
	logic signed [16:0] eb_q [3];
	pct_pkg::raw_t      raw_q [3];
	pct_pkg::nrm_t      floor_q [3];

	// output register
	logic m_tvalid_q;
	logic out_inside_q;
	logic out_ready_q;

	logic               accept;
	logic [1:0]         cidx;
	pct_pkg::coord_t    csel [3];
	logic [1:0]         pa, pb;
	pct_pkg::mac_ctl_t  ctl;
	logic signed [17:0] mx, my;
	pct_pkg::mac_res_t  res;
	logic               nstart;
	logic               ndone;
	pct_pkg::nrm_t      nout [3];
	logic               out_free;

	assign accept   = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {6'd0, out_ready_q, out_inside_q};

	// corner read port
	always_comb begin
		case (state_q)
			pct_pkg::S_BASE: cidx = floorph_q ? 2'd0 : k_q[1:0];
			pct_pkg::S_EA:   cidx = floorph_q ? 2'd1 : k_q[1:0] + 2'd1;
			pct_pkg::S_EB:   cidx = 2'd2;
			default:         cidx = k_q[1:0];  // plane k uses corner k mod 4
		endcase
		for (int i = 0; i < 3; i++) csel[i] = corner_q[cidx][i];
	end

	// component pairing for the negated cross product
	always_comb begin
		case (i_q)
			2'd0:    begin pa = 2'd2; pb = 2'd1; end
			2'd1:    begin pa = 2'd0; pb = 2'd2; end
			default: begin pa = 2'd1; pb = 2'd0; end
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			pct_pkg::S_IDLE: begin
				if (accept) begin
					if (s_tuser == pct_pkg::MODE_CORNER && count_q == 3'd3)
						state_d = pct_pkg::S_BASE;
					else if (s_tuser == pct_pkg::MODE_TEST && ready_q)
						state_d = pct_pkg::S_TEST;
					else
						state_d = pct_pkg::S_DONE;
				end
			end
			pct_pkg::S_BASE:   state_d = pct_pkg::S_EA;
			pct_pkg::S_EA:     state_d = floorph_q ? pct_pkg::S_EB : pct_pkg::S_CROSS;
			pct_pkg::S_EB:     state_d = pct_pkg::S_CROSS;
			pct_pkg::S_CROSS:  if (h_q && i_q == 2'd2) state_d = pct_pkg::S_CDRAIN;
			pct_pkg::S_CDRAIN: if (res.done && res.fin) state_d = pct_pkg::S_NORM;
			pct_pkg::S_NORM:   state_d = pct_pkg::S_NWAIT;
			pct_pkg::S_NWAIT: begin
				if (ndone) begin
					if (floorph_q || k_q < 3'd3) state_d = pct_pkg::S_BASE;
					else if (k_q == 3'd3) state_d = pct_pkg::S_NORM;
					else state_d = pct_pkg::S_THR;
				end
			end
			pct_pkg::S_TEST:   if (k_q == 3'd4 && i_q == 2'd2) state_d = pct_pkg::S_TDRAIN;
			pct_pkg::S_TDRAIN: if (res.done && res.fin) state_d = pct_pkg::S_DONE;
			pct_pkg::S_THR:    if (k_q == 3'd4 && i_q == 2'd2) state_d = pct_pkg::S_HDRAIN;
			pct_pkg::S_HDRAIN: if (res.done && res.fin) state_d = pct_pkg::S_DONE;
			pct_pkg::S_DONE:   if (out_free) state_d = pct_pkg::S_IDLE;
			default:           state_d = pct_pkg::S_IDLE;
		endcase
	end

	// outputs: handshake, multiplier issue, normalize start
	always_comb begin
		s_tready = (state_q == pct_pkg::S_IDLE);
		nstart   = (state_q == pct_pkg::S_NORM);
		ctl      = '0;
		mx       = '0;
		my       = '0;
		case (state_q)
			pct_pkg::S_CROSS: begin
				ctl.vld   = 1'b1;
				ctl.sub   = h_q;
				ctl.first = !h_q;
				ctl.last  = h_q;
				ctl.fin   = h_q && i_q == 2'd2;
				ctl.tag   = {1'b0, i_q};
				mx        = 18'(h_q ? ea_q[pb] : ea_q[pa]);
				my        = 18'(h_q ? eb_q[pa] : eb_q[pb]);
			end
			pct_pkg::S_TEST, pct_pkg::S_THR: begin
				ctl.vld   = 1'b1;
				ctl.first = i_q == 2'd0;
				ctl.last  = i_q == 2'd2;
				ctl.fin   = k_q == 3'd4 && i_q == 2'd2;
				ctl.tag   = k_q;
				if (state_q == pct_pkg::S_TEST) begin
					mx = 18'(v_q[i_q]);
					my = 18'(nrm_q[k_q][i_q]);
				end else begin
					// threshold term p * (n - eps)
					mx = 18'(csel[i_q]);
					my = 18'(nrm_q[k_q][i_q]) - 18'(pct_pkg::EpsQ14);
				end
			end
			default: ;
		endcase
	end

	pct_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.x      (mx),
		.y      (my),
		.res    (res)
	);

	pct_norm u_norm (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (nstart),
		.vec    (raw_q),
		.done   (ndone),
		.n      (nout)
	);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= pct_pkg::S_IDLE;
			count_q    <= '0;
			ready_q    <= 1'b0;
			m_tvalid_q <= 1'b0;
			floorph_q  <= 1'b0;
			k_q        <= '0;
			i_q        <= '0;
			h_q        <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == pct_pkg::S_DONE && out_free) m_tvalid_q <= 1'b1;
			else if (m_tready) m_tvalid_q <= 1'b0;

			case (state_q)
				pct_pkg::S_IDLE: begin
					k_q <= '0;
					i_q <= '0;
					if (accept) begin
						case (s_tuser)
							pct_pkg::MODE_CLEAR: begin
								count_q <= '0;
								ready_q <= 1'b0;
							end
							pct_pkg::MODE_CORNER: begin
								if (count_q < 3'(pct_pkg::NCorners)) count_q <= count_q + 3'd1;
								floorph_q <= 1'b1;
							end
							default: ;
						endcase
					end
				end
				pct_pkg::S_EA, pct_pkg::S_EB: begin
					i_q <= '0;
					h_q <= 1'b0;
				end
				pct_pkg::S_CROSS: begin
					h_q <= !h_q;
					if (h_q) i_q <= i_q + 2'd1;
				end
				pct_pkg::S_NWAIT: begin
					if (ndone) begin
						if (floorph_q) begin
							floorph_q <= 1'b0;
							k_q       <= '0;
						end else if (k_q == 3'd4) begin
							k_q <= '0;
							i_q <= '0;
						end else begin
							k_q <= k_q + 3'd1;
						end
					end
				end
				pct_pkg::S_TEST, pct_pkg::S_THR: begin
					if (i_q == 2'd2) begin
						i_q <= '0;
						k_q <= k_q + 3'd1;
					end else begin
						i_q <= i_q + 2'd1;
					end
				end
				pct_pkg::S_HDRAIN: if (res.done && res.fin) ready_q <= 1'b1;
				default: ;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			pct_pkg::S_IDLE: begin
				if (accept) begin
					mode_q   <= s_tuser;
					v_q[0]   <= s_tdata[15:0];
					v_q[1]   <= s_tdata[31:16];
					v_q[2]   <= s_tdata[47:32];
					// not calibrated: every tested point counts as inside
					inside_q <= (s_tuser == pct_pkg::MODE_TEST);
					if (s_tuser == pct_pkg::MODE_CORNER &&
					    count_q < 3'(pct_pkg::NCorners)) begin
						corner_q[count_q[1:0]][0] <= s_tdata[15:0];
						corner_q[count_q[1:0]][1] <= s_tdata[31:16];
						corner_q[count_q[1:0]][2] <= s_tdata[47:32];
					end
				end
			end
			pct_pkg::S_BASE: for (int i = 0; i < 3; i++) base_q[i] <= csel[i];
			pct_pkg::S_EA: begin
				for (int i = 0; i < 3; i++) begin
					ea_q[i] <= 17'(csel[i]) - 17'(base_q[i]);
					if (!floorph_q) eb_q[i] <= 17'(floor_q[i]);
				end
			end
			pct_pkg::S_EB: for (int i = 0; i < 3; i++) eb_q[i] <= 17'(csel[i]) - 17'(base_q[i]);
			pct_pkg::S_NWAIT: begin
				if (ndone) begin
					if (floorph_q) begin
						for (int i = 0; i < 3; i++) floor_q[i] <= nout[i];
					end else begin
						for (int i = 0; i < 3; i++) nrm_q[k_q][i] <= nout[i];
						// after the last side comes the flipped floor
						if (k_q == 3'd3)
							for (int i = 0; i < 3; i++) raw_q[i] <= -36'(floor_q[i]);
					end
				end
			end
			default: ;
		endcase

		if (res.done) begin
			case (state_q)
				pct_pkg::S_CROSS, pct_pkg::S_CDRAIN: raw_q[res.tag[1:0]] <= res.sum[35:0];
				pct_pkg::S_TEST, pct_pkg::S_TDRAIN: begin
					if ($signed(res.sum) > 40'(thr_q[res.tag])) inside_q <= 1'b0;
				end
				pct_pkg::S_THR, pct_pkg::S_HDRAIN: thr_q[res.tag] <= res.sum[35:0];
				default: ;
			endcase
		end

		if (state_q == pct_pkg::S_DONE && out_free) begin
			out_inside_q <= inside_q && mode_q == pct_pkg::MODE_TEST;
			out_ready_q  <= ready_q;
		end
	end

endmodule

/* tb/sv/tb_prism_containment_test.sv */
`timescale 1ns / 1ps

module tb_prism_containment_test;

	// run length and limits
	localparam int RandomWords = 680;
	localparam int CalmWords   = 100;    // last words go without idling
	localparam int DrainCycles = 800;    // longer than a full plane build
	localparam int CycleLimit  = 1000000;
	localparam int HoldCycles  = 400;    // long receiver hold-off
	localparam int HoldAtWord  = 120;

	typedef longint vec3_t [3];

	// one stimulus row; fixed rows carry a typed-in expectation
	typedef struct {
		logic [1:0]      mode;
		pct_pkg::coord_t x;
		pct_pkg::coord_t y;
		pct_pkg::coord_t z;
		logic            fixed;
		logic            in_hull;
		logic            rdy;
	} stim_row_t;

	typedef struct {
		logic in_hull;
		logic rdy;
	} verdict_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [1:0]  s_tuser = '0;
	logic [47:0] s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;

	stim_row_t stim_q [$];
	verdict_t  verdict_q [$];
	int        errors = 0;
	int        words_sent = 0;
	int        cycles = 0;
	bit        feed_done = 0;
	bit        calm = 0;

	// predictor state
	vec3_t  corner_mem [pct_pkg::NCorners];
	vec3_t  normal_mem [pct_pkg::NPlanes];
	longint thresh_mem [pct_pkg::NPlanes];
	int     corner_cnt;
	bit     planes_up;

	always #10 clk = ~clk;

	prism_containment_test i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tuser  (s_tuser),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	// integer square root, floor
	function automatic longint unsigned int_sqrt(longint unsigned s);
		longint unsigned r;
		longint unsigned b;
		r = 0;
		b = 64'd1 << 62;
		while (b > s) b = b >> 2;
		while (b != 0) begin
			if (s >= r + b) begin
				s = s - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	// scale to Q1.14 unit length, zero stays zero
	function automatic vec3_t unit_q14(vec3_t v);
		longint unsigned mag [3];
		longint unsigned big;
		longint unsigned r;
		longint q;
		vec3_t n;
		big = 0;
		for (int i = 0; i < 3; i++) begin
			mag[i] = (v[i] < 0) ? longint'(-v[i]) : longint'(v[i]);
			if (mag[i] > big) big = mag[i];
		end
		if (big == 0) begin
			n = '{0, 0, 0};
			return n;
		end
		while (big >= (64'd1 << 23)) begin
			big = big >> 1;
			for (int i = 0; i < 3; i++) mag[i] = mag[i] >> 1;
		end
		while (big < (64'd1 << 22)) begin
			big = big << 1;
			for (int i = 0; i < 3; i++) mag[i] = mag[i] << 1;
		end
		r = int_sqrt(mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2]);
		for (int i = 0; i < 3; i++) begin
			q = longint'(((mag[i] << 14) + (r >> 1)) / r);
			n[i] = (v[i] < 0) ? -q : q;
		end
		return n;
	endfunction

	// minus the cross product a x b
	function automatic vec3_t neg_cross(vec3_t a, vec3_t b);
		vec3_t c;
		c[0] = -(a[1] * b[2] - a[2] * b[1]);
		c[1] = -(a[2] * b[0] - a[0] * b[2]);
		c[2] = -(a[0] * b[1] - a[1] * b[0]);
		return c;
	endfunction

	function automatic vec3_t edge_vec(vec3_t a, vec3_t b);
		vec3_t d;
		for (int i = 0; i < 3; i++) d[i] = a[i] - b[i];
		return d;
	endfunction

	// floor, sides, flipped floor, then thresholds with the 0.01 margin
	task automatic build_planes();
		vec3_t floor_n;
		vec3_t flip;
		longint t;
		floor_n = unit_q14(neg_cross(edge_vec(corner_mem[1], corner_mem[0]),
			edge_vec(corner_mem[2], corner_mem[0])));
		for (int k = 0; k < pct_pkg::NCorners; k++)
			normal_mem[k] = unit_q14(neg_cross(
				edge_vec(corner_mem[(k + 1) % pct_pkg::NCorners], corner_mem[k]), floor_n));
		for (int i = 0; i < 3; i++) flip[i] = -floor_n[i];
		normal_mem[pct_pkg::NCorners] = unit_q14(flip);
		for (int k = 0; k < pct_pkg::NPlanes; k++) begin
			t = 0;
			for (int i = 0; i < 3; i++)
				t += corner_mem[k % pct_pkg::NCorners][i] * (normal_mem[k][i] - pct_pkg::EpsQ14);
			thresh_mem[k] = t;
		end
		planes_up = 1;
	endtask

	// advance the predictor by one word and give its verdict
	task automatic predict_word(stim_row_t w, output verdict_t vd);
		longint d;
		vd.in_hull = 1'b0;
		case (w.mode)
			pct_pkg::MODE_CLEAR: begin
				corner_cnt = 0;
				planes_up = 0;
			end
			pct_pkg::MODE_CORNER: begin
				// extra corners are dropped
				if (corner_cnt < pct_pkg::NCorners) begin
					corner_mem[corner_cnt] = '{longint'(w.x), longint'(w.y), longint'(w.z)};
					corner_cnt++;
					if (corner_cnt == pct_pkg::NCorners) build_planes();
				end
			end
			pct_pkg::MODE_TEST: begin
				vd.in_hull = 1'b1;
				if (planes_up) begin
					for (int k = 0; k < pct_pkg::NPlanes; k++) begin
						d = longint'(w.x) * normal_mem[k][0] + longint'(w.y) * normal_mem[k][1]
							+ longint'(w.z) * normal_mem[k][2];
						if (d > thresh_mem[k]) vd.in_hull = 1'b0;
					end
				end
			end
			default: ;    // mode three does nothing
		endcase
		vd.rdy = planes_up;
	endtask

	task automatic flag_mismatch(string what, logic got, logic want);
		$display("mismatch at cycle %0d: %s got %0b expected %0b", cycles, what, got, want);
		errors++;
	endtask

	function automatic stim_row_t row(logic [1:0] m, int x, int y, int z,
		logic fx = 0, logic ins = 0, logic rd = 0);
		stim_row_t r;
		r.mode = m;
		r.x = pct_pkg::coord_t'(x);
		r.y = pct_pkg::coord_t'(y);
		r.z = pct_pkg::coord_t'(z);
		r.fixed = fx;
		r.in_hull = ins;
		r.rdy = rd;
		return r;
	endfunction

	task automatic put_row(stim_row_t r);
		stim_q.insert(stim_q.size(), r);
	endtask

	function automatic int any_coord();
		return int'(pct_pkg::coord_t'($urandom));
	endfunction

	function automatic int near(int c, int spread);
		int v;
		v = c + int'($urandom_range(0, 2 * spread)) - spread;
		if (v > 32767) v = 32767;
		if (v < -32768) v = -32768;
		return v;
	endfunction

	// directed table, then random calibration and test sequences
	task automatic fill_stimulus();
		int x0, y0, x1, y1, z0, sz, ntest;
		bit wild;
		// untrained: all inside, not ready
		put_row(row(pct_pkg::MODE_TEST, 0, 0, 0, 1, 1, 0));
		put_row(row(pct_pkg::MODE_NOP, 0, 0, 0, 1, 0, 0));
		put_row(row(pct_pkg::MODE_CLEAR, 0, 0, 0, 1, 0, 0));
		// square floor of side 1024
		put_row(row(pct_pkg::MODE_CORNER, 0, 0, 0));
		put_row(row(pct_pkg::MODE_CORNER, 1024, 0, 0));
		put_row(row(pct_pkg::MODE_CORNER, 1024, 1024, 0));
		put_row(row(pct_pkg::MODE_CORNER, 0, 1024, 0));
		// fifth corner is ignored
		put_row(row(pct_pkg::MODE_CORNER, 32767, 32767, 32767));
		put_row(row(pct_pkg::MODE_TEST, 512, 512, 512));
		put_row(row(pct_pkg::MODE_TEST, -32768, -32768, -32768));
		put_row(row(pct_pkg::MODE_TEST, 32767, 32767, 32767));
		put_row(row(pct_pkg::MODE_TEST, 512, 512, -512));
		put_row(row(pct_pkg::MODE_NOP, -1, -1, -1, 1, 0, 1));
		put_row(row(pct_pkg::MODE_CLEAR, 0, 0, 0, 1, 0, 0));
		put_row(row(pct_pkg::MODE_TEST, 100, 100, 100, 1, 1, 0));
		// collinear corners give zero side normals
		put_row(row(pct_pkg::MODE_CORNER, 0, 0, 0));
		put_row(row(pct_pkg::MODE_CORNER, 1024, 1024, 1024));
		put_row(row(pct_pkg::MODE_CORNER, 2048, 2048, 2048));
		put_row(row(pct_pkg::MODE_CORNER, -32768, -32768, -32768));
		put_row(row(pct_pkg::MODE_TEST, 0, 0, 0));
		put_row(row(pct_pkg::MODE_TEST, 32767, -32768, 0));
		// corners at the coordinate extremes
		put_row(row(pct_pkg::MODE_CLEAR, 0, 0, 0, 1, 0, 0));
		put_row(row(pct_pkg::MODE_CORNER, -32768, -32768, -32768));
		put_row(row(pct_pkg::MODE_CORNER, 32767, -32768, 32767));
		put_row(row(pct_pkg::MODE_CORNER, 32767, 32767, -32768));
		put_row(row(pct_pkg::MODE_CORNER, -32768, 32767, 32767));
		put_row(row(pct_pkg::MODE_TEST, 0, 0, 0));

		while (stim_q.size() < RandomWords + 27) begin
			wild = ($urandom_range(0, 5) == 0);
			if ($urandom_range(0, 7) != 0) put_row(row(pct_pkg::MODE_CLEAR, any_coord(),
				any_coord(), any_coord()));
			sz = $urandom_range(64, 8000);
			x0 = near(0, 16000); y0 = near(0, 16000); z0 = near(0, 16000);
			x1 = near(x0 + sz, sz / 2); y1 = near(y0 + sz, sz / 2);
			if (wild) begin
				for (int i = 0; i < 4; i++)
					put_row(row(pct_pkg::MODE_CORNER, any_coord(), any_coord(), any_coord()));
			end else if ($urandom_range(0, 1) == 0) begin
				put_row(row(pct_pkg::MODE_CORNER, x0, y0, z0));
				put_row(row(pct_pkg::MODE_CORNER, x1, y0, near(z0, 50)));
				put_row(row(pct_pkg::MODE_CORNER, x1, y1, near(z0, 50)));
				put_row(row(pct_pkg::MODE_CORNER, x0, y1, near(z0, 50)));
			end else begin
				put_row(row(pct_pkg::MODE_CORNER, x0, y1, z0));
				put_row(row(pct_pkg::MODE_CORNER, x1, y1, near(z0, 50)));
				put_row(row(pct_pkg::MODE_CORNER, x1, y0, near(z0, 50)));
				put_row(row(pct_pkg::MODE_CORNER, x0, y0, near(z0, 50)));
			end
			if ($urandom_range(0, 4) == 0)
				put_row(row(pct_pkg::MODE_CORNER, any_coord(), any_coord(), any_coord()));
			ntest = $urandom_range(4, 16);
			for (int i = 0; i < ntest; i++) begin
				case ($urandom_range(0, 9))
					0: put_row(row(pct_pkg::MODE_TEST, any_coord(), any_coord(), any_coord()));
					1: put_row(row(pct_pkg::MODE_NOP, any_coord(), any_coord(), any_coord()));
					default: put_row(row(pct_pkg::MODE_TEST, near((x0 + x1) / 2, sz),
						near((y0 + y1) / 2, sz), near(z0, sz)));
				endcase
			end
		end
	endtask

	// reset and stimulus feed; inputs move only on the falling edge
	initial begin
		stim_row_t w;
		verdict_t vd;
		corner_cnt = 0;
		planes_up = 0;
		fill_stimulus();
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		foreach (stim_q[n]) begin
			w = stim_q[n];
			calm = (n >= stim_q.size() - CalmWords);
			// random idle burst before this word
			if (!calm && $urandom_range(0, 5) == 0) begin
				s_tvalid = 1'b0;
				repeat ($urandom_range(1, 19)) @(negedge clk);
			end
			s_tuser = w.mode;
			s_tdata = {w.z, w.y, w.x};
			s_tvalid = 1'b1;
			@(posedge clk);
			while (!s_tready) @(posedge clk);
			predict_word(w, vd);
			if (w.fixed) begin
				if (vd.in_hull !== w.in_hull)
					flag_mismatch("table inside", vd.in_hull, w.in_hull);
				if (vd.rdy !== w.rdy) flag_mismatch("table ready", vd.rdy, w.rdy);
				vd.in_hull = w.in_hull;
				vd.rdy = w.rdy;
			end
			verdict_q.insert(verdict_q.size(), vd);
			words_sent++;
			@(negedge clk);
		end
		s_tvalid = 1'b0;
		feed_done = 1;
	end

	// receiver: random stalls plus one long hold-off so the block backs up
	initial begin
		int hold;
		bit held;
		hold = 0;
		held = 0;
		forever begin
			@(negedge clk);
			if (!held && words_sent >= HoldAtWord) begin
				held = 1;
				hold = HoldCycles;
			end
			if (hold > 0) begin
				m_tready = 1'b0;
				hold--;
			end else if (!calm && $urandom_range(0, 7) == 0) begin
				m_tready = 1'b0;
				hold = $urandom_range(0, 18);
			end else begin
				m_tready = 1'b1;
			end
		end
	end

	// compare each result word with the oldest verdict
	always @(posedge clk) begin
		verdict_t vd;
		if (arst_n && m_tvalid && m_tready) begin
			if (verdict_q.size() == 0) begin
				flag_mismatch("unexpected word", 1'b1, 1'b0);
			end else begin
				vd = verdict_q.pop_front();
				if (m_tdata[0] !== vd.in_hull) flag_mismatch("inside_res", m_tdata[0], vd.in_hull);
				if (m_tdata[1] !== vd.rdy) flag_mismatch("ready_res", m_tdata[1], vd.rdy);
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CycleLimit) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// wait for the last result, let the block settle, then judge
	initial begin
		wait (feed_done);
		while (verdict_q.size() != 0) @(posedge clk);
		repeat (DrainCycles) @(posedge clk);
		if (verdict_q.size() != 0) errors++;
		if (errors == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule

/* prism_containment_test.f */
rtl/pct_pkg.sv
rtl/pct_mac.sv
rtl/pct_norm.sv
rtl/prism_containment_test.sv
tb/sv/tb_prism_containment_test.sv
